### src/dcsc_pkg.sv
// Shared constants and types for the dual-code sliding correlator.
package dcsc_pkg;

    localparam int WINDOW_LEN  = 31;
    localparam int SAMPLE_BITS = 16;
    localparam int CODE_BITS   = 31;
    localparam int OUT_BITS    = 21;
    localparam int TERM_BITS   = SAMPLE_BITS + 1;
    localparam int FILL_BITS   = $clog2(WINDOW_LEN + 1);

    // adder tree: groups of four terms, then two halves of four groups
    localparam int GROUP_LEN  = 4;
    localparam int N_GROUPS   = 8;
    localparam int HALF_LEN   = N_GROUPS / 2;
    localparam int GROUP_BITS = TERM_BITS + 2;
    localparam int HALF_BITS  = GROUP_BITS + 2;

    localparam int CFG_IDX_BITS = 1;

    localparam logic [CODE_BITS-1:0] CODE_A_RESET = CODE_BITS'(586135424);
    localparam logic [CODE_BITS-1:0] CODE_B_RESET = CODE_BITS'(1175731536);

    localparam logic [CFG_IDX_BITS-1:0] REG_CODE_A = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CODE_B = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [TERM_BITS-1:0]   t_term;
    typedef logic signed [GROUP_BITS-1:0]  t_group;
    typedef logic signed [HALF_BITS-1:0]   t_half;
    typedef logic signed [OUT_BITS-1:0]    t_corr;

endpackage

### src/dcsc_cell.sv
// One window cell: holds a sample, passes it on, forms both weighted terms.
module dcsc_cell (
    input  logic             i_clk,
    input  logic             i_shift,
    input  dcsc_pkg::t_sample i_sample,
    input  logic             i_bit_a,
    input  logic             i_bit_b,
    output dcsc_pkg::t_sample o_sample,
    output dcsc_pkg::t_term   o_term_a,
    output dcsc_pkg::t_term   o_term_b
);

    dcsc_pkg::t_sample r_sample;
    dcsc_pkg::t_sample n_sample;
    dcsc_pkg::t_term   w_neg;

    always_comb begin
        n_sample = i_shift ? i_sample : r_sample;
    end

    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
    end

    // chip weight is -1 where the code bit is set
    assign w_neg    = -{r_sample[dcsc_pkg::SAMPLE_BITS-1], r_sample};
    assign o_sample = r_sample;
    assign o_term_a = i_bit_a ? w_neg : '0;
    assign o_term_b = i_bit_b ? w_neg : '0;

endmodule

### src/dcsc_sum.sv
// Three-stage registered adder tree over the weighted window terms.
module dcsc_sum (
    input  logic            i_clk,
    input  logic            i_en,
    input  dcsc_pkg::t_term i_terms [dcsc_pkg::WINDOW_LEN],
    output dcsc_pkg::t_corr o_corr
);

    dcsc_pkg::t_term  w_pad   [dcsc_pkg::N_GROUPS*dcsc_pkg::GROUP_LEN];
    dcsc_pkg::t_group n_group [dcsc_pkg::N_GROUPS];
    dcsc_pkg::t_group r_group [dcsc_pkg::N_GROUPS];
    dcsc_pkg::t_half  n_half  [2];
    dcsc_pkg::t_half  r_half  [2];
    dcsc_pkg::t_corr  n_corr;
    dcsc_pkg::t_corr  r_corr;

    always_comb begin
        for (int k = 0; k < dcsc_pkg::N_GROUPS*dcsc_pkg::GROUP_LEN; k++) begin
            w_pad[k] = '0;
        end
        for (int k = 0; k < dcsc_pkg::WINDOW_LEN; k++) begin
            w_pad[k] = i_terms[k];
        end
    end

    always_comb begin
        for (int g = 0; g < dcsc_pkg::N_GROUPS; g++) begin
            n_group[g] = '0;
            for (int j = 0; j < dcsc_pkg::GROUP_LEN; j++) begin
                n_group[g] = n_group[g]
                           + dcsc_pkg::GROUP_BITS'(w_pad[g*dcsc_pkg::GROUP_LEN + j]);
            end
        end
    end

    always_comb begin
        for (int h = 0; h < 2; h++) begin
            n_half[h] = '0;
            for (int j = 0; j < dcsc_pkg::HALF_LEN; j++) begin
                n_half[h] = n_half[h]
                          + dcsc_pkg::HALF_BITS'(r_group[h*dcsc_pkg::HALF_LEN + j]);
            end
        end
    end

    // full-window sum is bounded to the output range
    assign n_corr = dcsc_pkg::OUT_BITS'(dcsc_pkg::OUT_BITS'(r_half[0])
                                      + dcsc_pkg::OUT_BITS'(r_half[1]));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_group <= n_group;
            r_half  <= n_half;
            r_corr  <= n_corr;
        end
    end

    assign o_corr = r_corr;

endmodule

### src/dual_code_sliding_correlator_core.sv
// Dual-code sliding correlator: top level with window chain and result pipeline.
//
// Input channel: i_in_valid / o_in_ready carry one signed 16-bit sample per request.
// Output channel: o_out_valid / i_out_ready carry the pair o_corr_a / o_corr_b,
// the negated sums of the 31 window samples whose code bit is set.
// Configuration: i_cfg_we writes i_cfg_data into code word A (index 0) or
// code word B (index 1) at the clock edge; write only while no request is in flight.
// The window is a chain of 31 cells; each accepted sample shifts in at the
// newest end. The first 30 samples give no result; every sample after that
// gives one result pair.
// Throughput: one sample per clock while the output is not stalled. An accepted
// sample is registered in the window cells, then in the three adder tree stages.
// Reset (synchronous, active low) marks the window empty and restores both codes.
// A stalled receiver freezes the whole pipeline; o_in_ready drops only while
// a result is held and not taken.
module dual_code_sliding_correlator_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [dcsc_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [dcsc_pkg::OUT_BITS-1:0]    o_corr_a,
    output logic signed [dcsc_pkg::OUT_BITS-1:0]    o_corr_b,
    input  logic                                i_cfg_we,
    input  logic [dcsc_pkg::CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  logic [dcsc_pkg::CODE_BITS-1:0]          i_cfg_data
);

    logic [dcsc_pkg::CODE_BITS-1:0] r_code_a, r_code_b;
    logic [dcsc_pkg::CODE_BITS-1:0] n_code_a, n_code_b;
    logic [dcsc_pkg::FILL_BITS-1:0] r_fill, n_fill;
    logic r_v_win, r_v_grp, r_v_half, r_v_out;
    logic w_en, w_accept;

    dcsc_pkg::t_sample w_chain  [dcsc_pkg::WINDOW_LEN+1];
    dcsc_pkg::t_term   w_term_a [dcsc_pkg::WINDOW_LEN];
    dcsc_pkg::t_term   w_term_b [dcsc_pkg::WINDOW_LEN];

    assign w_en       = !r_v_out || i_out_ready;
    assign w_accept   = i_in_valid && w_en;
    assign o_in_ready = w_en;

    always_comb begin
        n_code_a = r_code_a;
        n_code_b = r_code_b;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                dcsc_pkg::REG_CODE_A: n_code_a = i_cfg_data;
                dcsc_pkg::REG_CODE_B: n_code_b = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_fill = r_fill;
        if (w_accept && (r_fill != dcsc_pkg::FILL_BITS'(dcsc_pkg::WINDOW_LEN))) begin
            n_fill = r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_a <= dcsc_pkg::CODE_A_RESET;
            r_code_b <= dcsc_pkg::CODE_B_RESET;
            r_fill   <= '0;
            r_v_win  <= 1'b0;
            r_v_grp  <= 1'b0;
            r_v_half <= 1'b0;
            r_v_out  <= 1'b0;
        end else begin
            r_code_a <= n_code_a;
            r_code_b <= n_code_b;
            r_fill   <= n_fill;
            if (w_en) begin
                r_v_win  <= w_accept
                            && (n_fill == dcsc_pkg::FILL_BITS'(dcsc_pkg::WINDOW_LEN));
                r_v_grp  <= r_v_win;
                r_v_half <= r_v_grp;
                r_v_out  <= r_v_half;
            end
        end
    end

    // newest sample enters at the top cell, oldest sits in cell 0
    assign w_chain[dcsc_pkg::WINDOW_LEN] = i_sample;

    for (genvar k = 0; k < dcsc_pkg::WINDOW_LEN; k++) begin : g_cell
        dcsc_cell u_cell (
            .i_clk    (i_clk),
            .i_shift  (w_accept),
            .i_sample (w_chain[k+1]),
            .i_bit_a  (r_code_a[k]),
            .i_bit_b  (r_code_b[k]),
            .o_sample (w_chain[k]),
            .o_term_a (w_term_a[k]),
            .o_term_b (w_term_b[k])
        );
    end

    dcsc_sum u_sum_a (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_terms (w_term_a),
        .o_corr  (o_corr_a)
    );

    dcsc_sum u_sum_b (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_terms (w_term_b),
        .o_corr  (o_corr_b)
    );

    assign o_out_valid = r_v_out;

endmodule
